>>> hdl/health_aware_round_robin_select_core_assert.svh
// ============================================================================
// Assertion macros for the health-aware round-robin selector
// Concurrent assertion wrappers that compile away for synthesis.
// ============================================================================
`ifndef HEALTH_AWARE_ROUND_ROBIN_SELECT_CORE_ASSERT_SVH
`define HEALTH_AWARE_ROUND_ROBIN_SELECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that the antecedent implies the consequent in the same cycle.
`define HARRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the antecedent implies the consequent in the following cycle.
`define HARRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HARRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define HARRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/harrs_pkg.sv
`default_nettype none
// ============================================================================
// Health-aware round-robin selector package
// Shared codes, field widths and controller/datapath interface structs.
// ============================================================================
package harrs_pkg;

    localparam int COUNT_W   = 5;
    localparam int THRESH_W  = 4;
    localparam int FIELD_W   = 4;
    localparam int FAILCNT_W = 4;

    localparam logic [FAILCNT_W-1:0] FAILCNT_MAX = 4'd15;

    // Request operations.
    localparam logic [1:0] OP_SELECT  = 2'd0;
    localparam logic [1:0] OP_FAIL    = 2'd1;
    localparam logic [1:0] OP_SUCCESS = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_ALL_DOWN     = 2'd1;
    localparam logic [1:0] ST_NO_SERVERS   = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SERVER_COUNT      = 1'b0;
    localparam logic CFG_FAILURE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic commit_sel;
        logic commit_rep;
        logic commit_empty;
        logic rep_fail;
    } harrs_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] op;
        logic       n_zero;
        logic       out_free;
    } harrs_stat_t;

endpackage

`default_nettype wire

>>> hdl/harrs_ctrl.sv
`default_nettype none
// ============================================================================
// Selector controller
// Sequences request intake, the pointer reduction and the commit of results.
// ============================================================================
module harrs_ctrl
    import harrs_pkg::*;
#(
    parameter int MAX_BACKENDS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire harrs_stat_t stat,
    output harrs_cmd_t       cmd,
    output logic             in_ready
);

    localparam int IDX_W = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int SW    = $clog2(IDX_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_REPORT,
        S_EMPTY
    } state_t;

    state_t          state_reg;
    logic [SW-1:0]   step_reg;
    logic            fail_reg;
    logic            accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_ready && stat.in_valid;

    always_comb
    begin
        cmd              = '0;
        cmd.rep_fail     = fail_reg;
        cmd.load         = accept && ((stat.op == OP_SELECT && !stat.n_zero) ||
                                      stat.op == OP_FAIL || stat.op == OP_SUCCESS);
        cmd.mod_step     = (state_reg == S_MOD);
        cmd.commit_sel   = (state_reg == S_SCAN)   && stat.out_free;
        cmd.commit_rep   = (state_reg == S_REPORT) && stat.out_free;
        cmd.commit_empty = (state_reg == S_EMPTY)  && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (stat.op) inside
                            OP_SELECT:
                            begin
                                step_reg  <= SW'(IDX_W - 1);
                                state_reg <= stat.n_zero ? S_EMPTY : S_MOD;
                            end
                            OP_FAIL, OP_SUCCESS:
                            begin
                                fail_reg  <= (stat.op == OP_FAIL);
                                state_reg <= S_REPORT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MOD:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                S_SCAN, S_REPORT, S_EMPTY:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/harrs_dp.sv
`default_nettype none
// ============================================================================
// Selector datapath
// Health state, rotation pointer, pointer reduction and rotating scan.
// ============================================================================
module harrs_dp
    import harrs_pkg::*;
#(
    parameter int MAX_BACKENDS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire harrs_cmd_t           cmd,
    input  wire logic [COUNT_W-1:0]   server_count,
    input  wire logic [THRESH_W-1:0]  failure_threshold,
    input  wire logic [FIELD_W-1:0]   server_index,
    output logic [1:0]                status,
    output logic [FIELD_W-1:0]        chosen_index,
    output logic                      server_alive
);

    localparam int IDX_W = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int NW    = $clog2(MAX_BACKENDS + 1);
    localparam int EW    = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int DW    = EW + IDX_W;

    logic [IDX_W-1:0]      ptr_reg;
    logic [MAX_BACKENDS-1:0] alive_reg;
    logic [FAILCNT_W-1:0]  fail_cnt_reg [MAX_BACKENDS];
    logic [FIELD_W-1:0]    idx_reg;
    logic [IDX_W-1:0]      rem_reg;
    logic [DW-1:0]         dsh_reg;
    logic [1:0]            status_reg;
    logic [FIELD_W-1:0]    chosen_reg;
    logic                  alive_out_reg;

    logic [EW-1:0]         n_eff;
    logic [MAX_BACKENDS-1:0] live_m;
    logic [MAX_BACKENDS-1:0] upper_m;
    logic [MAX_BACKENDS-1:0] pick_m;
    logic [MAX_BACKENDS-1:0] iso_m;
    logic [IDX_W-1:0]      pick_idx;
    logic                  any_alive;
    logic [IDX_W-1:0]      next_ptr;
    logic [IDX_W+FIELD_W-1:0] pick_wide;
    logic [IDX_W+FIELD_W-1:0] idx_wide;
    logic [IDX_W-1:0]      rep_idx;
    logic                  in_range;
    logic [THRESH_W-1:0]   thr_eff;
    logic                  cur_alive;
    logic [FAILCNT_W-1:0]  cur_cnt;
    logic [FAILCNT_W-1:0]  cnt_inc;
    logic [FAILCNT_W-1:0]  cnt_new;
    logic                  alive_new;

    // Servers beyond the built capacity are not in rotation.
    always_comb
    begin
        if (EW'(server_count) > EW'(MAX_BACKENDS))
        begin
            n_eff = EW'(MAX_BACKENDS);
        end
        else
        begin
            n_eff = EW'(server_count);
        end
    end

    // Rotating scan: alive servers at or above the reduced pointer win first,
    // otherwise the lowest alive server wraps around.
    always_comb
    begin
        for (int i = 0; i < MAX_BACKENDS; i++)
        begin
            live_m[i]  = alive_reg[i] && (EW'(i) < n_eff);
            upper_m[i] = live_m[i] && (EW'(i) >= EW'(rem_reg));
        end
        pick_m    = (upper_m != '0) ? upper_m : live_m;
        iso_m     = pick_m & (~pick_m + 1'b1);
        any_alive = (live_m != '0);
        pick_idx  = '0;
        for (int i = 0; i < MAX_BACKENDS; i++)
        begin
            if (iso_m[i])
            begin
                pick_idx = pick_idx | IDX_W'(i);
            end
        end
        if ((EW'(pick_idx) + 1'b1) == n_eff)
        begin
            next_ptr = '0;
        end
        else
        begin
            next_ptr = pick_idx + 1'b1;
        end
        pick_wide = {{FIELD_W{1'b0}}, pick_idx};
    end

    // Health report update for the addressed server.
    always_comb
    begin
        idx_wide  = {{IDX_W{1'b0}}, idx_reg};
        rep_idx   = idx_wide[IDX_W-1:0];
        in_range  = (DW'(idx_reg) < DW'(n_eff));
        thr_eff   = (failure_threshold == '0) ? THRESH_W'(1) : failure_threshold;
        cur_alive = alive_reg[rep_idx];
        cur_cnt   = fail_cnt_reg[rep_idx];
        cnt_inc   = (cur_cnt == FAILCNT_MAX) ? FAILCNT_MAX : cur_cnt + 1'b1;
        if (cmd.rep_fail)
        begin
            if (cur_alive)
            begin
                cnt_new   = cnt_inc;
                alive_new = !(cnt_inc >= thr_eff);
            end
            else
            begin
                cnt_new   = cur_cnt;
                alive_new = 1'b0;
            end
        end
        else
        begin
            cnt_new   = '0;
            alive_new = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            alive_reg <= '1;
            for (int i = 0; i < MAX_BACKENDS; i++)
            begin
                fail_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.commit_sel)
            begin
                ptr_reg <= any_alive ? next_ptr : rem_reg;
            end
            if (cmd.commit_rep && in_range)
            begin
                alive_reg[rep_idx]    <= alive_new;
                fail_cnt_reg[rep_idx] <= cnt_new;
            end
        end
    end

    // Pointer reduction modulo the active count, one restoring step a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= server_index;
            rem_reg <= ptr_reg;
            dsh_reg <= DW'(n_eff) << (IDX_W - 1);
        end
        else if (cmd.mod_step)
        begin
            if (DW'(rem_reg) >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg[IDX_W-1:0];
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_sel)
        begin
            status_reg    <= any_alive ? ST_OK : ST_ALL_DOWN;
            chosen_reg    <= any_alive ? pick_wide[FIELD_W-1:0] : '0;
            alive_out_reg <= any_alive;
        end
        else if (cmd.commit_rep)
        begin
            status_reg    <= in_range ? ST_OK : ST_OUT_OF_RANGE;
            chosen_reg    <= idx_reg;
            alive_out_reg <= in_range && alive_new;
        end
        else if (cmd.commit_empty)
        begin
            status_reg    <= ST_NO_SERVERS;
            chosen_reg    <= '0;
            alive_out_reg <= 1'b0;
        end
    end

    assign status       = status_reg;
    assign chosen_index = chosen_reg;
    assign server_alive = alive_out_reg;

endmodule

`default_nettype wire

>>> hdl/health_aware_round_robin_select_core.sv
// Order: a health report's result word is registered from its report state after acceptance; a
// select's result word follows the one-bit-per-cycle reduction of the rotation pointer modulo the
// active count and the rotating scan; a select with no servers goes straight to its empty result.
// Flow: one request at a time; the next is accepted only once the block is idle again after the
// result registers, and a receiver that stalls the output holds the block busy.
// Reset: rst_n clears the pointer, marks every server alive and zeroes all failure counts.
`default_nettype none
// ============================================================================
// Health-aware round-robin server selector
// Picks the next alive server in rotation and tracks per-server health.
// ============================================================================
`include "health_aware_round_robin_select_core_assert.svh"

module health_aware_round_robin_select_core
    import harrs_pkg::*;
#(
    parameter int MAX_BACKENDS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // Request stream.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [3:0] server_index, [7:4] zero
    input  wire logic [1:0] s_axis_tuser,   // [1:0] operation

    // Result stream.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [3:0] chosen_index, [4] server_alive, [7:5] zero
    output logic [1:0]      m_axis_tuser,   // [1:0] status

    // Configuration write channel.
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [4:0] cfg_data
);

    // Configuration registers. Writes must only be made while the block is idle;
    // the user must keep to this, the block does not enforce it. The channel is always ready.
    logic [COUNT_W-1:0]  server_count_reg;
    logic [THRESH_W-1:0] failure_threshold_reg;

    // Result word holding register valid flag.
    logic                m_valid_reg;

    harrs_cmd_t          cmd;
    harrs_stat_t         stat;
    logic                commit;
    logic [1:0]          status;
    logic [FIELD_W-1:0]  chosen_index;
    logic                server_alive;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg      <= COUNT_W'(1);
            failure_threshold_reg <= THRESH_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SERVER_COUNT:      server_count_reg      <= cfg_data;
                CFG_FAILURE_THRESHOLD: failure_threshold_reg <= cfg_data[THRESH_W-1:0];
                default:               server_count_reg      <= server_count_reg;
            endcase
        end
    end

    // The controller may commit a new result word whenever the output
    // register is empty or is being drained in the same cycle.
    assign stat.in_valid = s_axis_tvalid;
    assign stat.op       = s_axis_tuser;
    assign stat.n_zero   = (server_count_reg == '0);
    assign stat.out_free = !m_valid_reg || m_axis_tready;

    assign commit = cmd.commit_sel || cmd.commit_rep || cmd.commit_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    harrs_ctrl #(
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    harrs_dp #(
        .MAX_BACKENDS (MAX_BACKENDS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .server_count      (server_count_reg),
        .failure_threshold (failure_threshold_reg),
        .server_index      (s_axis_tdata[FIELD_W-1:0]),
        .status            (status),
        .chosen_index      (chosen_index),
        .server_alive      (server_alive)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, server_alive, chosen_index};
    assign m_axis_tuser  = status;

    // An ignored operation leaves the block ready for the next word.
    `HARRS_ASSERT_NEXT(a_none_stays_ready, clk, rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_NONE,
        s_axis_tready, "ignored operation left the block busy")

    // Every committed result shows up as a valid output word.
    `HARRS_ASSERT_NEXT(a_commit_gives_word, clk, rst_n, commit, m_axis_tvalid,
        "committed result did not reach the output")

    // An out-of-range report never claims the server is alive.
    `HARRS_ASSERT_NOW(a_range_not_alive, clk, rst_n,
        m_axis_tvalid && m_axis_tuser == ST_OUT_OF_RANGE, !m_axis_tdata[4],
        "out-of-range report flagged alive")

endmodule

`default_nettype wire
